/* rtl/kast_pkg.sv */
// Shared constants for the key/action state tracker.
// Table geometry, counter limits and request opcodes.
// No dependencies.
package kast_pkg;

    // Table and action geometry
    localparam int NUM_ACTIONS = 32;
    localparam int NUM_SLOTS   = 32;
    localparam int ACT_W       = $clog2(NUM_ACTIONS);
    localparam int SLOT_W      = $clog2(NUM_SLOTS);

    // Map register file: 8 words of four 16-bit slots
    localparam int NUM_WORDS   = 8;
    localparam int WORD_W      = 64;
    localparam int CFG_IDX_W   = 4;

    // Scan always walks the full 32-entry table span
    localparam int SCAN_LEN    = 32;
    localparam int CNT_W       = 5;

    // Field widths
    localparam int OP_W        = 3;
    localparam int AXIS_W      = 32;
    localparam int KEY_W       = 8;
    localparam int CNT_DN_W    = 6;
    localparam logic [CNT_DN_W-1:0] COUNT_MAX = '1;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_KEY_DOWN    = 3'd0;
    localparam logic [OP_W-1:0] OP_KEY_UP      = 3'd1;
    localparam logic [OP_W-1:0] OP_AXIS_ABS    = 3'd2;
    localparam logic [OP_W-1:0] OP_AXIS_REL    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ        = 3'd4;
    localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd5;
    localparam logic [OP_W-1:0] OP_FRAME_TICK  = 3'd6;

endpackage

/* rtl/key_action_state_tracker_unit.sv */
// Key/action state tracker: mapping table, per-action state and request sequencer.
// Depends on kast_pkg.
//
// Each request is captured at the accepting edge. A single slot comparator
// then walks the mapping table one slot per cycle (release-all and
// frame-tick do their per-slot and per-action work in the same pass), an
// apply step updates the action state and a done step loads the result
// register. in_stall stays high from acceptance until the result is loaded,
// so a new request is only taken once the last one's result is loaded. The
// next request is taken while that result waits on out_stall, but a result
// is only loaded once the previous one has been taken. Map registers are
// written through the cfg port (always ready, index beyond 7 ignored) and
// should only change while no request is in flight.
module key_action_state_tracker_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Request channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [kast_pkg::OP_W-1:0]             opcode,
    input  logic [4:0]                            action,
    input  logic [kast_pkg::KEY_W-1:0]            system_key,
    input  logic signed [kast_pkg::AXIS_W-1:0]    axis_amount,

    // Result channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  found,
    output logic                                  is_down,
    output logic                                  released,
    output logic signed [kast_pkg::AXIS_W-1:0]    axis_value,
    output logic signed [kast_pkg::AXIS_W-1:0]    axis_delta,

    // Map register write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kast_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kast_pkg::WORD_W-1:0]           cfg_data
);
    import kast_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } state_t;

    // Sequencer and latched request
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [4:0]           act_reg, act_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [AXIS_W-1:0]    amt_reg, amt_next;

    // Scan results
    logic                 first_found_reg, first_found_next;
    logic [SLOT_W-1:0]    first_idx_reg, first_idx_next;
    logic                 exact_found_reg, exact_found_next;
    logic [SLOT_W-1:0]    exact_idx_reg, exact_idx_next;

    // Map table
    logic [WORD_W-1:0]    map_reg [NUM_WORDS];
    logic [WORD_W-1:0]    map_next [NUM_WORDS];

    // Per-slot and per-action state
    logic                 held_reg [NUM_SLOTS];
    logic                 held_next [NUM_SLOTS];
    logic [CNT_DN_W-1:0]  dc_reg [NUM_ACTIONS];
    logic [CNT_DN_W-1:0]  dc_next [NUM_ACTIONS];
    logic                 rel_reg [NUM_ACTIONS];
    logic                 rel_next [NUM_ACTIONS];
    logic [AXIS_W-1:0]    value_reg [NUM_ACTIONS];
    logic [AXIS_W-1:0]    value_next [NUM_ACTIONS];
    logic [AXIS_W-1:0]    delta_reg [NUM_ACTIONS];
    logic [AXIS_W-1:0]    delta_next [NUM_ACTIONS];
    logic                 cons_reg [NUM_ACTIONS];
    logic                 cons_next [NUM_ACTIONS];

    // Result register
    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic                 down_reg, down_next;
    logic                 released_reg, released_next;
    logic [AXIS_W-1:0]    value_out_reg, value_out_next;
    logic [AXIS_W-1:0]    delta_out_reg, delta_out_next;

    // Current scan slot decode
    logic [15:0]          slot_bits;
    logic [4:0]           slot_act;
    logic [KEY_W-1:0]     slot_key;
    logic                 slot_in;
    logic                 slot_act_ok;
    logic                 slot_usable;
    logic [SLOT_W-1:0]    slot_idx;
    logic [ACT_W-1:0]     slot_act_idx;
    logic [ACT_W-1:0]     scan_act_idx;
    logic [ACT_W-1:0]     act_idx;
    logic [SLOT_W-1:0]    tgt_idx;
    logic [CNT_DN_W-1:0]  dc_dec;

    assign slot_bits    = map_reg[cnt_reg[4:2]][{cnt_reg[1:0], 4'b0000} +: 16];
    assign slot_act     = slot_bits[12:8];
    assign slot_key     = slot_bits[7:0];
    assign slot_in      = int'(cnt_reg) < NUM_SLOTS;
    assign slot_act_ok  = int'(slot_act) < NUM_ACTIONS;
    assign slot_usable  = slot_in && slot_bits[15] && slot_act_ok;
    assign slot_idx     = cnt_reg[SLOT_W-1:0];
    assign slot_act_idx = slot_act[ACT_W-1:0];
    assign scan_act_idx = cnt_reg[ACT_W-1:0];
    assign act_idx      = act_reg[ACT_W-1:0];

    // Key events with a nonzero key prefer the exact slot
    assign tgt_idx = ((op_reg == OP_KEY_DOWN || op_reg == OP_KEY_UP) && key_reg != '0
                      && exact_found_reg) ? exact_idx_reg : first_idx_reg;

    // Shared down-count decrement, read at the slot action or the request action
    assign dc_dec = (state_reg == ST_SCAN) ?
                    ((dc_reg[slot_act_idx] != '0) ? dc_reg[slot_act_idx] - 1'b1 : '0) :
                    ((dc_reg[act_idx] != '0) ? dc_reg[act_idx] - 1'b1 : '0);

    assign in_stall   = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign found      = found_reg;
    assign is_down    = down_reg;
    assign released   = released_reg;
    assign axis_value = signed'(value_out_reg);
    assign axis_delta = signed'(delta_out_reg);

    // Next-state logic
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        op_next          = op_reg;
        act_next         = act_reg;
        key_next         = key_reg;
        amt_next         = amt_reg;
        first_found_next = first_found_reg;
        first_idx_next   = first_idx_reg;
        exact_found_next = exact_found_reg;
        exact_idx_next   = exact_idx_reg;
        map_next         = map_reg;
        held_next        = held_reg;
        dc_next          = dc_reg;
        rel_next         = rel_reg;
        value_next       = value_reg;
        delta_next       = delta_reg;
        cons_next        = cons_reg;
        out_valid_next   = out_valid_reg;
        found_next       = found_reg;
        down_next        = down_reg;
        released_next    = released_reg;
        value_out_next   = value_out_reg;
        delta_out_next   = delta_out_reg;

        // Map register writes
        if (cfg_valid && int'(cfg_index) < NUM_WORDS)
        begin
            map_next[cfg_index[2:0]] = cfg_data;
        end

        // Result taken downstream
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = opcode;
                    act_next         = action;
                    key_next         = system_key;
                    amt_next         = $unsigned(axis_amount);
                    cnt_next         = '0;
                    first_found_next = 1'b0;
                    exact_found_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // Slot resolution
                if (slot_usable && slot_act == act_reg)
                begin
                    if (!first_found_reg)
                    begin
                        first_found_next = 1'b1;
                        first_idx_next   = slot_idx;
                    end
                    if (slot_key == key_reg && !exact_found_reg)
                    begin
                        exact_found_next = 1'b1;
                        exact_idx_next   = slot_idx;
                    end
                end

                // Release-all: drop each held slot against its current action
                if (op_reg == OP_RELEASE_ALL && slot_in && held_reg[slot_idx])
                begin
                    held_next[slot_idx] = 1'b0;
                    if (slot_act_ok)
                    begin
                        dc_next[slot_act_idx] = dc_dec;
                        if (dc_dec == '0)
                        begin
                            rel_next[slot_act_idx] = 1'b1;
                        end
                    end
                end

                // Frame tick: clear release flag, zero consumed deltas
                if (op_reg == OP_FRAME_TICK && int'(cnt_reg) < NUM_ACTIONS)
                begin
                    rel_next[scan_act_idx] = 1'b0;
                    if (cons_reg[scan_act_idx])
                    begin
                        delta_next[scan_act_idx] = '0;
                        cons_next[scan_act_idx]  = 1'b0;
                    end
                end

                cnt_next = cnt_reg + 1'b1;
                if (int'(cnt_reg) == SCAN_LEN - 1)
                begin
                    state_next = ST_APPLY;
                end
            end

            ST_APPLY:
            begin
                if (first_found_reg)
                begin
                    case (op_reg)
                        OP_KEY_DOWN:
                        begin
                            if (!held_reg[tgt_idx])
                            begin
                                held_next[tgt_idx] = 1'b1;
                                if (dc_reg[act_idx] != COUNT_MAX)
                                begin
                                    dc_next[act_idx] = dc_reg[act_idx] + 1'b1;
                                end
                            end
                        end
                        OP_KEY_UP:
                        begin
                            if (held_reg[tgt_idx])
                            begin
                                held_next[tgt_idx] = 1'b0;
                                dc_next[act_idx]   = dc_dec;
                                if (dc_dec == '0)
                                begin
                                    rel_next[act_idx] = 1'b1;
                                end
                            end
                        end
                        OP_AXIS_ABS:
                        begin
                            delta_next[act_idx] = amt_reg - value_reg[act_idx];
                            value_next[act_idx] = amt_reg;
                            cons_next[act_idx]  = 1'b0;
                        end
                        OP_AXIS_REL:
                        begin
                            value_next[act_idx] = value_reg[act_idx] + amt_reg;
                            delta_next[act_idx] = delta_reg[act_idx] + amt_reg;
                            cons_next[act_idx]  = 1'b0;
                        end
                        OP_READ:
                        begin
                            cons_next[act_idx] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // Load result once the previous one has left
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    found_next     = first_found_reg;
                    down_next      = first_found_reg && (dc_reg[act_idx] != '0);
                    released_next  = first_found_reg && rel_reg[act_idx];
                    value_out_next = first_found_reg ? value_reg[act_idx] : '0;
                    delta_out_next = first_found_reg ? delta_reg[act_idx] : '0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            op_reg          <= '0;
            act_reg         <= '0;
            key_reg         <= '0;
            amt_reg         <= '0;
            first_found_reg <= 1'b0;
            first_idx_reg   <= '0;
            exact_found_reg <= 1'b0;
            exact_idx_reg   <= '0;
            out_valid_reg   <= 1'b0;
            found_reg       <= 1'b0;
            down_reg        <= 1'b0;
            released_reg    <= 1'b0;
            value_out_reg   <= '0;
            delta_out_reg   <= '0;
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                held_reg[s] <= 1'b0;
            end
            for (int a = 0; a < NUM_ACTIONS; a++)
            begin
                dc_reg[a]    <= '0;
                rel_reg[a]   <= 1'b0;
                value_reg[a] <= '0;
                delta_reg[a] <= '0;
                cons_reg[a]  <= 1'b0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            op_reg          <= op_next;
            act_reg         <= act_next;
            key_reg         <= key_next;
            amt_reg         <= amt_next;
            first_found_reg <= first_found_next;
            first_idx_reg   <= first_idx_next;
            exact_found_reg <= exact_found_next;
            exact_idx_reg   <= exact_idx_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            down_reg        <= down_next;
            released_reg    <= released_next;
            value_out_reg   <= value_out_next;
            delta_out_reg   <= delta_out_next;
            map_reg         <= map_next;
            held_reg        <= held_next;
            dc_reg          <= dc_next;
            rel_reg         <= rel_next;
            value_reg       <= value_next;
            delta_reg       <= delta_next;
            cons_reg        <= cons_next;
        end
    end

    // An accepted request always starts a table scan
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == ST_SCAN)
        else $error("accepted request did not start a scan");

    // A new result only appears right after the done step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the done step");

    // An exact key match is never found before the first action match
    assert property (@(posedge clk) disable iff (!rst_n)
        exact_found_reg |-> first_found_reg && first_idx_reg <= exact_idx_reg)
        else $error("exact match without earlier action match");

    // Unresolved actions report an all-zero result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !found_reg |-> !down_reg && !released_reg
            && value_out_reg == '0 && delta_out_reg == '0)
        else $error("unresolved result carries state");

endmodule

/* tb/sv/kast_report_checker.sv */
// Report checker for the key/action state tracker.
// Mirrors the map registers and the per-slot and per-action state, predicts
// the one report that each request produces and compares it. Depends on kast_pkg.
module kast_report_checker
    import kast_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [OP_W-1:0]          opcode,
    input  logic [4:0]               action,
    input  logic [KEY_W-1:0]         system_key,
    input  logic signed [AXIS_W-1:0] axis_amount,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     found,
    input  logic                     is_down,
    input  logic                     released,
    input  logic signed [AXIS_W-1:0] axis_value,
    input  logic signed [AXIS_W-1:0] axis_delta,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    output int                       fail_count,
    output int                       outstanding
);

    typedef struct packed {
        logic              found;
        logic              down;
        logic              rel;
        logic [AXIS_W-1:0] value;
        logic [AXIS_W-1:0] delta;
    } action_report_t;

    // Mirrored map registers and tracker state
    logic [WORD_W-1:0]   map_q      [NUM_WORDS];
    logic                held_q     [SCAN_LEN];
    logic [CNT_DN_W-1:0] press_cnt  [SCAN_LEN];
    logic                rel_flag   [SCAN_LEN];
    logic [AXIS_W-1:0]   value_q    [SCAN_LEN];
    logic [AXIS_W-1:0]   delta_q    [SCAN_LEN];
    logic                consumed_q [SCAN_LEN];

    action_report_t pending_reports[$];

    initial fail_count = 0;

    function automatic logic [15:0] slot_word(int s);
        return map_q[s / 4][(s % 4) * 16 +: 16];
    endfunction

    // Append one predicted report behind those already waiting
    function automatic void queue_report(action_report_t rpt);
        pending_reports.insert(pending_reports.size(), rpt);
    endfunction

    // First usable slot of the action; with exact set and a nonzero key the
    // key must match too, falling back to the first slot of the action.
    function automatic int find_slot(logic [4:0] act, logic [KEY_W-1:0] key, bit exact);
        logic [15:0] w;
        if (int'(act) >= NUM_ACTIONS)
            return -1;
        if (exact && key != '0)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                w = slot_word(s);
                if (w[15] && int'(w[12:8]) < NUM_ACTIONS && w[12:8] == act && w[7:0] == key)
                    return s;
            end
        end
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            w = slot_word(s);
            if (w[15] && int'(w[12:8]) < NUM_ACTIONS && w[12:8] == act)
                return s;
        end
        return -1;
    endfunction

    // Drop one press; reaching zero marks the action released
    function automatic void drop_press(logic [4:0] act);
        if (int'(act) >= NUM_ACTIONS)
            return;
        if (press_cnt[act] != '0)
            press_cnt[act] = press_cnt[act] - 1'b1;
        if (press_cnt[act] == '0)
            rel_flag[act] = 1'b1;
    endfunction

    function automatic void clear_state();
        for (int i = 0; i < NUM_WORDS; i++)
            map_q[i] = '0;
        for (int i = 0; i < SCAN_LEN; i++)
        begin
            held_q[i]     = 1'b0;
            press_cnt[i]  = '0;
            rel_flag[i]   = 1'b0;
            value_q[i]    = '0;
            delta_q[i]    = '0;
            consumed_q[i] = 1'b0;
        end
    endfunction

    // Apply one request to the mirrored state and build its report
    function automatic action_report_t step_action_state(logic [OP_W-1:0] op,
                                                         logic [4:0] act,
                                                         logic [KEY_W-1:0] key,
                                                         logic [AXIS_W-1:0] amt);
        int hit;
        logic [15:0] w;
        action_report_t rpt;
        hit = find_slot(act, key, op == OP_KEY_DOWN || op == OP_KEY_UP);
        if (op == OP_RELEASE_ALL)
        begin
            // drop goes to the slot's current action, valid or not
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                if (held_q[s])
                begin
                    held_q[s] = 1'b0;
                    w = slot_word(s);
                    drop_press(w[12:8]);
                end
            end
        end
        else if (op == OP_FRAME_TICK)
        begin
            for (int a = 0; a < SCAN_LEN; a++)
            begin
                rel_flag[a] = 1'b0;
                if (consumed_q[a])
                begin
                    delta_q[a]    = '0;
                    consumed_q[a] = 1'b0;
                end
            end
        end
        else if (hit >= 0)
        begin
            case (op)
                OP_KEY_DOWN:
                begin
                    if (!held_q[hit])
                    begin
                        held_q[hit] = 1'b1;
                        if (press_cnt[act] != COUNT_MAX)
                            press_cnt[act] = press_cnt[act] + 1'b1;
                    end
                end
                OP_KEY_UP:
                begin
                    if (held_q[hit])
                    begin
                        held_q[hit] = 1'b0;
                        drop_press(act);
                    end
                end
                OP_AXIS_ABS:
                begin
                    delta_q[act]    = amt - value_q[act];
                    value_q[act]    = amt;
                    consumed_q[act] = 1'b0;
                end
                OP_AXIS_REL:
                begin
                    value_q[act]    = value_q[act] + amt;
                    delta_q[act]    = delta_q[act] + amt;
                    consumed_q[act] = 1'b0;
                end
                OP_READ: consumed_q[act] = 1'b1;
                default: ;
            endcase
        end

        rpt = '0;
        if (find_slot(act, '0, 1'b0) >= 0)
        begin
            rpt.found = 1'b1;
            rpt.down  = press_cnt[act] != '0;
            rpt.rel   = rel_flag[act];
            rpt.value = value_q[act];
            rpt.delta = delta_q[act];
        end
        return rpt;
    endfunction

    task automatic check_field(string name, logic [AXIS_W-1:0] want, logic [AXIS_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Map writes first, then the report leaving, then the request arriving
    always @(posedge clk or negedge rst_n)
    begin
        action_report_t want;
        if (!rst_n)
        begin
            clear_state();
            pending_reports.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && int'(cfg_index) < NUM_WORDS)
                map_q[cfg_index[2:0]] = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (pending_reports.size() == 0)
                begin
                    $error("report with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("found", 32'(want.found), 32'(found));
                    check_field("is_down", 32'(want.down), 32'(is_down));
                    check_field("released", 32'(want.rel), 32'(released));
                    check_field("axis_value", want.value, axis_value);
                    check_field("axis_delta", want.delta, axis_delta);
                end
            end

            if (in_valid && !in_stall)
                queue_report(step_action_state(opcode, action, system_key, axis_amount));

            outstanding <= pending_reports.size();
        end
    end

endmodule

/* tb/sv/tb_key_action_state_tracker_unit.sv */
// Top of the key/action state tracker testbench: clock, reset, map programming,
// request stimulus and the random result back-pressure.
// Depends on kast_pkg, key_action_state_tracker_unit and kast_report_checker.
module tb_key_action_state_tracker_unit;
    import kast_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int IDLE_PCT       = 28;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 215;
    localparam int ZERO_MAP_ITEMS = 30;
    localparam int QUIET_PHASE    = 3;
    localparam int PRESSURE_PHASE = 4;

    typedef enum logic [1:0] {MAP_RANDOM, MAP_ALL_ONES, MAP_ALL_ZERO} map_style_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          opcode      = '0;
    logic [4:0]               action      = '0;
    logic [KEY_W-1:0]         system_key  = '0;
    logic signed [AXIS_W-1:0] axis_amount = '0;
    logic                     out_valid;
    logic                     out_stall   = 1'b0;
    logic                     found;
    logic                     is_down;
    logic                     released;
    logic signed [AXIS_W-1:0] axis_value;
    logic signed [AXIS_W-1:0] axis_delta;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [WORD_W-1:0]        cfg_data    = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int idle_pct    = IDLE_PCT;
    int hold_left   = 0;

    logic [WORD_W-1:0] map_img  [NUM_WORDS];
    logic [4:0]        act_pool [4];
    logic [KEY_W-1:0]  key_pool [4];

    key_action_state_tracker_unit uut (.*);

    kast_report_checker report_check (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    // Offer one request, idling first at random, and hold it until taken.
    // Valid is left high; settle() lowers it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [4:0] act,
                                input logic [KEY_W-1:0] key, input logic [AXIS_W-1:0] amt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        action      <= act;
        system_key  <= key;
        axis_amount <= amt;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop offering and wait for every report to come back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_map(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Write all map words, then one index beyond the map that must be dropped
    task automatic program_map();
        for (int w = 0; w < NUM_WORDS; w++)
            write_map(CFG_IDX_W'(w), map_img[w]);
        write_map(CFG_IDX_W'($urandom_range(NUM_WORDS, 15)), {$urandom, $urandom});
        cfg_valid <= 1'b0;
    endtask

    // Slot with random don't-care bits 14:13
    function automatic logic [15:0] make_slot(bit valid, logic [4:0] act, logic [KEY_W-1:0] key);
        return {valid, 2'($urandom_range(3)), act, key};
    endfunction

    function automatic logic [WORD_W-1:0] random_map_word();
        logic [WORD_W-1:0] w;
        for (int k = 0; k < 4; k++)
        begin
            if ($urandom_range(9) == 0)
                w[k*16 +: 16] = 16'($urandom);
            else
                w[k*16 +: 16] = make_slot($urandom_range(99) < 75, act_pool[$urandom_range(3)],
                                          key_pool[$urandom_range(3)]);
        end
        return w;
    endfunction

    // Small action and key sets so events keep hitting mapped slots
    task automatic pick_pools();
        for (int i = 0; i < 4; i++)
        begin
            act_pool[i] = 5'($urandom_range(31));
            key_pool[i] = KEY_W'($urandom_range(1, 255));
        end
        if ($urandom_range(2) == 0)
            key_pool[3] = '0;
        if ($urandom_range(3) == 0)
            act_pool[0] = '0;
        if ($urandom_range(3) == 0)
            act_pool[1] = '1;
    endtask

    task automatic build_map(input map_style_t style);
        for (int w = 0; w < NUM_WORDS; w++)
        begin
            case (style)
                MAP_ALL_ONES: map_img[w] = '1;
                MAP_ALL_ZERO: map_img[w] = '0;
                default:      map_img[w] = random_map_word();
            endcase
        end
    endtask

    // Mostly key traffic on pooled actions and keys, with stray values mixed in
    task automatic random_request();
        int pick;
        logic [OP_W-1:0]   op;
        logic [4:0]        act;
        logic [KEY_W-1:0]  key;
        logic [AXIS_W-1:0] amt;
        pick = $urandom_range(99);
        if (pick < 30)
            op = OP_KEY_DOWN;
        else if (pick < 55)
            op = OP_KEY_UP;
        else if (pick < 63)
            op = OP_AXIS_ABS;
        else if (pick < 73)
            op = OP_AXIS_REL;
        else if (pick < 86)
            op = OP_READ;
        else if (pick < 90)
            op = OP_RELEASE_ALL;
        else if (pick < 97)
            op = OP_FRAME_TICK;
        else
            op = OP_UNUSED;
        act = ($urandom_range(9) == 0) ? 5'($urandom) : act_pool[$urandom_range(3)];
        case ($urandom_range(9))
            0:       key = '0;
            1:       key = KEY_W'($urandom);
            default: key = key_pool[$urandom_range(3)];
        endcase
        amt = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200) - 100;
        send_request(op, act, key, amt);
    endtask

    initial
    begin
        map_style_t style;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Known table: action 1 on keys 10/11 (plus a shadowed duplicate),
        // action 2 on key FF, action 3 only on an invalid slot, action 31 on
        // keys 01 and 00, action 0 on key 20, top word all ones.
        map_img[0] = 64'hE2FF_E110_8111_8110;
        map_img[1] = 64'h9F00_8020_9F01_0333;
        for (int w = 2; w < NUM_WORDS - 1; w++)
            map_img[w] = '0;
        map_img[NUM_WORDS-1] = '1;
        program_map();

        // Press counting by edge across two keys of one action
        send_request(OP_KEY_DOWN, 5'd1, 8'h10, '0);
        send_request(OP_KEY_DOWN, 5'd1, 8'h10, '0);
        send_request(OP_KEY_DOWN, 5'd1, 8'h11, '0);
        send_request(OP_KEY_UP, 5'd1, 8'h10, '0);
        send_request(OP_KEY_UP, 5'd1, 8'h10, '0);
        send_request(OP_KEY_UP, 5'd1, 8'h11, '0);
        // No key and an unmapped key both fall back to the first slot
        send_request(OP_KEY_DOWN, 5'd1, 8'h00, '0);
        send_request(OP_KEY_DOWN, 5'd1, 8'h77, '0);
        send_request(OP_KEY_DOWN, 5'd2, 8'hFF, '1);
        send_request(OP_RELEASE_ALL, 5'd1, 8'h00, '0);
        send_request(OP_READ, 5'd1, 8'h00, '0);
        send_request(OP_FRAME_TICK, 5'd1, 8'h00, '0);
        // Axis wrap at both ends, consume and clear of the delta
        send_request(OP_AXIS_ABS, 5'd2, 8'h00, 32'h7FFF_FFFF);
        send_request(OP_AXIS_REL, 5'd2, 8'h00, 32'h0000_0001);
        send_request(OP_AXIS_ABS, 5'd2, 8'h00, 32'h8000_0000);
        send_request(OP_READ, 5'd2, 8'h00, '0);
        send_request(OP_FRAME_TICK, 5'd2, 8'h00, '0);
        send_request(OP_READ, 5'd2, 8'h00, '0);
        send_request(OP_AXIS_REL, 5'd31, 8'h00, 32'hFFFF_FFFF);
        // Action with only an invalid slot is ignored
        send_request(OP_AXIS_REL, 5'd3, 8'h00, 32'd5);
        send_request(OP_KEY_DOWN, 5'd3, 8'h33, '0);
        send_request(OP_KEY_DOWN, 5'd31, 8'hFF, '0);
        send_request(OP_UNUSED, 5'd31, 8'hFF, '0);
        // Left held so a later remap changes what release-all drops
        send_request(OP_KEY_DOWN, 5'd0, 8'h20, '0);
        send_request(OP_READ, 5'd0, 8'h00, '0);

        // Random phases, each on a fresh table
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            pick_pools();
            if (ph == 2)
                style = MAP_ALL_ONES;
            else if (ph == 5)
                style = MAP_ALL_ZERO;
            else
                style = MAP_RANDOM;
            build_map(style);
            program_map();
            idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
            if (ph == PRESSURE_PHASE)
                hold_left = HOLD_CYCLES;
            repeat ((style == MAP_ALL_ZERO) ? ZERO_MAP_ITEMS : PHASE_ITEMS)
                random_request();
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
